// ----- rtl/core/i2cseq_pkg.sv -----
// Shared types, constants and codes for the I2C master byte sequencer.
package i2cseq_pkg;

  // Default width of the phase tick counter.
  localparam int unsigned PhaseCountBitsDef = 16;

  // Configuration register widths and reset values.
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned PhaseW   = 16;
  localparam int unsigned TimeoutW = 8;

  localparam logic [PhaseW-1:0]   PhaseTicksRst    = PhaseW'(10);
  localparam logic [PhaseW-1:0]   AckPhaseTicksRst = PhaseW'(6);
  localparam logic [PhaseW-1:0]   ReadHoldTicksRst = PhaseW'(5);
  localparam logic [TimeoutW-1:0] AckTimeoutRst    = TimeoutW'(250);

  // Stream word widths.
  localparam int unsigned InDataW  = 16;
  localparam int unsigned InUserW  = 3;
  localparam int unsigned OutDataW = 16;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PHASE_TICKS     = 2'd0,
    CFG_ACK_PHASE_TICKS = 2'd1,
    CFG_READ_HOLD_TICKS = 2'd2,
    CFG_ACK_TIMEOUT     = 2'd3
  } cfg_idx_e;

  // Command codes carried on the input word.
  typedef enum logic [2:0] {
    CMD_START = 3'd0,
    CMD_STOP  = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_WAIT  = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e;

  // Sequencer phases.
  typedef enum logic [4:0] {
    S_IDLE    = 5'd0,
    S_ST_A    = 5'd1,
    S_ST_B    = 5'd2,
    S_SP_A    = 5'd3,
    S_SP_B    = 5'd4,
    S_WR_D    = 5'd5,
    S_WR_H    = 5'd6,
    S_WR_L    = 5'd7,
    S_WA_R    = 5'd8,
    S_WA_H    = 5'd9,
    S_WA_POLL = 5'd10,
    S_RD_L    = 5'd11,
    S_RD_H    = 5'd12,
    S_AK_L    = 5'd13,
    S_AK_H    = 5'd14
  } seq_state_e;

  typedef struct packed {
    logic [PhaseW-1:0]   phase_ticks;
    logic [PhaseW-1:0]   ack_phase_ticks;
    logic [PhaseW-1:0]   read_hold_ticks;
    logic [TimeoutW-1:0] ack_timeout;
  } cfg_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_sample;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_error;
  } result_t;

endpackage

// ----- rtl/core/i2c_master_byte_sequencer.sv -----
// Top level of the I2C master byte sequencer: stream ports, settings and output register.
// A result word appears on the master side in the cycle after its tick word is accepted.
// One tick word per cycle when the output has room; the state advances once per accepted word.
// The output register lets a new word in whenever the held result leaves in the same cycle.
// Reset (asynchronous, active low) idles the sequencer with SCL and SDA high and driven,
// clears the error flag and received byte, and loads the default phase lengths and timeout.
module i2c_master_byte_sequencer #(
  parameter int unsigned PHASE_COUNT_BITS = i2cseq_pkg::PhaseCountBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Tick words in.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // Bits from 0: cmd_valid, tx_byte[7:0], send_ack, sda_sample, zero fill.
  input  logic [i2cseq_pkg::InDataW-1:0]    s_axis_tdata,
  // Bits from 0: command[2:0].
  input  logic [i2cseq_pkg::InUserW-1:0]    s_axis_tuser,
  // Result words out.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // Bits from 0: scl_level, sda_level, sda_drive, busy_res, done_res,
  // rx_byte[7:0], ack_error, zero fill.
  output logic [i2cseq_pkg::OutDataW-1:0]   m_axis_tdata,
  // Register write port.
  input  logic                              cfg_we_i,
  input  logic [i2cseq_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [i2cseq_pkg::CfgDataW-1:0]   cfg_data_i
);
  import i2cseq_pkg::*;

  cfg_t     cfg_q;
  in_item_t item;
  result_t  core_res, out_res;
  logic     step;
  logic     out_free;

  // Plain registers, one per write; user writes only with the sequencer idle, not enforced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_ticks     <= PhaseTicksRst;
      cfg_q.ack_phase_ticks <= AckPhaseTicksRst;
      cfg_q.read_hold_ticks <= ReadHoldTicksRst;
      cfg_q.ack_timeout     <= AckTimeoutRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PHASE_TICKS:     cfg_q.phase_ticks     <= cfg_data_i[PhaseW-1:0];
        CFG_ACK_PHASE_TICKS: cfg_q.ack_phase_ticks <= cfg_data_i[PhaseW-1:0];
        CFG_READ_HOLD_TICKS: cfg_q.read_hold_ticks <= cfg_data_i[PhaseW-1:0];
        CFG_ACK_TIMEOUT:     cfg_q.ack_timeout     <= cfg_data_i[TimeoutW-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the tick word.
  assign item.cmd_valid  = s_axis_tdata[0];
  assign item.tx_byte    = s_axis_tdata[8:1];
  assign item.send_ack   = s_axis_tdata[9];
  assign item.sda_sample = s_axis_tdata[10];
  assign item.command    = s_axis_tuser;

  // Every tick produces exactly one result, so a word is taken only when the
  // output register has room for that result.
  assign s_axis_tready = out_free;
  assign step          = s_axis_tvalid && s_axis_tready;

  i2cseq_core #(
    .PHASE_COUNT_BITS(PHASE_COUNT_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item),
    .cfg_i    (cfg_q),
    .result_o (core_res)
  );

  i2cseq_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (step),
    .result_i (core_res),
    .ready_i  (m_axis_tready),
    .valid_o  (m_axis_tvalid),
    .free_o   (out_free),
    .result_o (out_res)
  );

  // Pack the result word.
  assign m_axis_tdata = {2'b00, out_res.ack_error, out_res.rx_byte, out_res.done_res,
                         out_res.busy_res, out_res.sda_drive, out_res.sda_level,
                         out_res.scl_level};

  // A completing command always leaves the sequencer idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[4] && m_axis_tdata[3]))
    else $error("done and busy reported together");

  // An empty output register never stalls the tick stream.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  // Every accepted tick yields a result word on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
    else $error("accepted tick produced no result word");

endmodule

// ----- rtl/core/i2cseq_core.sv -----
// Sequencer state registers and the per-tick next-state logic.
module i2cseq_core #(
  parameter int unsigned PHASE_COUNT_BITS = i2cseq_pkg::PhaseCountBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  i2cseq_pkg::in_item_t  item_i,
  input  i2cseq_pkg::cfg_t      cfg_i,
  output i2cseq_pkg::result_t   result_o
);
  import i2cseq_pkg::*;

  localparam logic [PHASE_COUNT_BITS-1:0] PhaseMax = '1;

  seq_state_e                  st_q, st_d, ent_st;
  logic [PHASE_COUNT_BITS-1:0] phase_q, phase_d;
  logic [3:0]                  bc_q, bc_d;
  logic [7:0]                  shift_q, shift_d, shift_base;
  logic [7:0]                  poll_q, poll_d;
  logic                        ack_q, ack_d;
  logic                        err_q, err_d;
  logic                        scl_q, scl_d;
  logic                        sda_q, sda_d;
  logic                        dir_q, dir_d;
  logic [7:0]                  rx_q, rx_d;

  logic do_enter, finish, go_idle, go_poll, dec, scl_low, rx_load;
  logic poll_inc, err_set, err_clr, bc_inc, bc_clr, sh_load_tx, sh_clr, ack_load;
  logic poll_now;
  logic [PhaseW-1:0] len;

  // A zero length still lasts one tick; lengths past the counter saturate.
  function automatic logic [PHASE_COUNT_BITS-1:0] load_len(input logic [PhaseW-1:0] d);
    logic [PhaseW-1:0] v;
    logic              sat;
    v   = (d == '0) ? '0 : d - PhaseW'(1);
    sat = (PHASE_COUNT_BITS < PhaseW) && ((v >> PHASE_COUNT_BITS) != '0);
    return sat ? PhaseMax : PHASE_COUNT_BITS'(v);
  endfunction

  // Transition decision for one tick.
  always_comb begin
    do_enter   = 1'b0;
    ent_st     = S_IDLE;
    finish     = 1'b0;
    go_idle    = 1'b0;
    go_poll    = 1'b0;
    dec        = 1'b0;
    scl_low    = 1'b0;
    rx_load    = 1'b0;
    poll_inc   = 1'b0;
    err_set    = 1'b0;
    err_clr    = 1'b0;
    bc_inc     = 1'b0;
    bc_clr     = 1'b0;
    sh_load_tx = 1'b0;
    sh_clr     = 1'b0;
    ack_load   = 1'b0;
    // Polling happens in the poll phase and on the tick the high phase runs out.
    poll_now   = (st_q == S_WA_POLL) || (st_q == S_WA_H && phase_q == '0);

    if (st_q != S_IDLE) begin
      if (poll_now) begin
        go_poll = (st_q == S_WA_H);
        if (!item_i.sda_sample) begin
          scl_low = 1'b1;
          err_clr = 1'b1;
          finish  = 1'b1;
        end else if (poll_q >= cfg_i.ack_timeout) begin
          err_set  = 1'b1;
          do_enter = 1'b1;
          ent_st   = S_SP_A;
        end else begin
          poll_inc = 1'b1;
        end
      end else if (phase_q != '0) begin
        dec = 1'b1;
      end else begin
        case (st_q)
          S_ST_A: begin
            do_enter = 1'b1;
            ent_st   = S_ST_B;
          end
          S_ST_B: begin
            scl_low = 1'b1;
            finish  = 1'b1;
          end
          S_SP_A: begin
            do_enter = 1'b1;
            ent_st   = S_SP_B;
          end
          S_SP_B: finish = 1'b1;
          S_WR_D: begin
            do_enter = 1'b1;
            ent_st   = S_WR_H;
          end
          S_WR_H: begin
            do_enter = 1'b1;
            ent_st   = S_WR_L;
          end
          S_WR_L: begin
            bc_inc = 1'b1;
            if ((bc_q + 4'd1) >= 4'd8) begin
              finish = 1'b1;
            end else begin
              do_enter = 1'b1;
              ent_st   = S_WR_D;
            end
          end
          S_WA_R: begin
            do_enter = 1'b1;
            ent_st   = S_WA_H;
          end
          S_RD_L: begin
            do_enter = 1'b1;
            ent_st   = S_RD_H;
          end
          S_RD_H: begin
            bc_inc   = 1'b1;
            do_enter = 1'b1;
            ent_st   = ((bc_q + 4'd1) >= 4'd8) ? S_AK_L : S_RD_L;
          end
          S_AK_L: begin
            do_enter = 1'b1;
            ent_st   = S_AK_H;
          end
          S_AK_H: begin
            scl_low = 1'b1;
            rx_load = 1'b1;
            finish  = 1'b1;
          end
          default: go_idle = 1'b1;
        endcase
      end
    end else if (item_i.cmd_valid) begin
      bc_clr = 1'b1;
      case (cmd_e'(item_i.command))
        CMD_START: begin
          do_enter = 1'b1;
          ent_st   = S_ST_A;
        end
        CMD_STOP: begin
          do_enter = 1'b1;
          ent_st   = S_SP_A;
        end
        CMD_WRITE: begin
          sh_load_tx = 1'b1;
          do_enter   = 1'b1;
          ent_st     = S_WR_D;
        end
        CMD_WAIT: begin
          do_enter = 1'b1;
          ent_st   = S_WA_R;
        end
        CMD_READ: begin
          sh_clr   = 1'b1;
          ack_load = 1'b1;
          do_enter = 1'b1;
          ent_st   = S_RD_L;
        end
        default: ;
      endcase
    end
  end

  // Register updates, including the pin actions of the phase being entered.
  always_comb begin
    st_d    = st_q;
    phase_d = phase_q;
    poll_d  = poll_q;
    ack_d   = ack_load ? item_i.send_ack : ack_q;
    err_d   = err_set ? 1'b1 : (err_clr ? 1'b0 : err_q);
    scl_d   = scl_low ? 1'b0 : scl_q;
    sda_d   = sda_q;
    dir_d   = dir_q;
    rx_d    = rx_load ? shift_q : rx_q;
    bc_d    = bc_clr ? 4'd0 : (bc_inc ? bc_q + 4'd1 : bc_q);
    len     = cfg_i.phase_ticks;

    shift_base = sh_load_tx ? item_i.tx_byte : (sh_clr ? 8'd0 : shift_q);
    shift_d    = shift_base;

    // An ack seen on the first poll ends the command at once.
    if (go_poll)           st_d = S_WA_POLL;
    if (finish || go_idle) st_d = S_IDLE;
    if (poll_inc)          poll_d = poll_q + 8'd1;
    if (dec)               phase_d = phase_q - PHASE_COUNT_BITS'(1);

    if (do_enter) begin
      st_d = ent_st;
      case (ent_st)
        S_ST_A: begin
          dir_d = 1'b1;
          sda_d = 1'b1;
          scl_d = 1'b1;
        end
        S_ST_B: sda_d = 1'b0;
        S_SP_A: begin
          dir_d = 1'b1;
          scl_d = 1'b0;
          sda_d = 1'b0;
        end
        S_SP_B: begin
          scl_d = 1'b1;
          sda_d = 1'b1;
        end
        S_WR_D: begin
          dir_d   = 1'b1;
          scl_d   = 1'b0;
          sda_d   = shift_base[7];
          shift_d = {shift_base[6:0], 1'b0};
        end
        S_WR_H: scl_d = 1'b1;
        S_WR_L: scl_d = 1'b0;
        S_WA_R: begin
          dir_d  = 1'b0;
          sda_d  = 1'b1;
          poll_d = 8'd0;
          len    = cfg_i.ack_phase_ticks;
        end
        S_WA_H: begin
          scl_d = 1'b1;
          len   = cfg_i.ack_phase_ticks;
        end
        S_RD_L: begin
          dir_d = 1'b0;
          sda_d = 1'b1;
          scl_d = 1'b0;
        end
        S_RD_H: begin
          scl_d   = 1'b1;
          shift_d = {shift_base[6:0], item_i.sda_sample};
          len     = cfg_i.read_hold_ticks;
        end
        S_AK_L: begin
          scl_d = 1'b0;
          dir_d = 1'b1;
          sda_d = ~ack_q;
        end
        S_AK_H: scl_d = 1'b1;
        default: ;
      endcase
      phase_d = load_len(len);
    end
  end

  // The result of this tick is the state it leaves behind.
  always_comb begin
    result_o.scl_level = scl_d;
    result_o.sda_level = sda_d;
    result_o.sda_drive = dir_d;
    result_o.busy_res  = (st_d != S_IDLE);
    result_o.done_res  = finish;
    result_o.rx_byte   = rx_d;
    result_o.ack_error = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      phase_q <= '0;
      bc_q    <= 4'd0;
      shift_q <= 8'd0;
      poll_q  <= 8'd0;
      ack_q   <= 1'b0;
      err_q   <= 1'b0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      dir_q   <= 1'b1;
      rx_q    <= 8'd0;
    end else if (step_i) begin
      st_q    <= st_d;
      phase_q <= phase_d;
      bc_q    <= bc_d;
      shift_q <= shift_d;
      poll_q  <= poll_d;
      ack_q   <= ack_d;
      err_q   <= err_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      dir_q   <= dir_d;
      rx_q    <= rx_d;
    end
  end

endmodule

// ----- rtl/core/i2cseq_out_reg.sv -----
// Output register holding one result word until the downstream side takes it.
module i2cseq_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  i2cseq_pkg::result_t  result_i,
  input  logic                 ready_i,
  output logic                 valid_o,
  output logic                 free_o,
  output i2cseq_pkg::result_t  result_o
);
  import i2cseq_pkg::*;

  logic    valid_q, valid_d;
  result_t data_q;

  // The register can take a new word when empty or when its word leaves now.
  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = data_q;

endmodule
